// ===== src/plr_pkg.sv =====
// ----------------------------------------------------------------------------
// plr_pkg
// Shared widths, datapath operation codes and controller/datapath types for
// the polyline arc length resampler.
// ----------------------------------------------------------------------------
package plr_pkg;

    localparam int COORD_W    = 32;
    localparam int STEP_W     = 20;
    localparam int ARC_W      = 40;
    localparam int LEN_W      = 33;
    localparam int POS_W      = 34;
    localparam int PROD_W     = 66;
    localparam int MUL_B_W    = 32;
    localparam int CNT_W      = 6;
    localparam int ROOT_STEPS = 33;
    localparam int DIV_STEPS  = 33;
    localparam int ITER_W     = $clog2(ROOT_STEPS + 1);

    localparam logic [STEP_W-1:0] STEP_RESET = 20'd1000;

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_MANY = 2'd2;

    typedef logic [4:0] t_op;

    localparam t_op OP_NOP    = 5'd0;
    localparam t_op OP_LINE   = 5'd1;
    localparam t_op OP_LOAD   = 5'd2;
    localparam t_op OP_SQX    = 5'd3;
    localparam t_op OP_SQY    = 5'd4;
    localparam t_op OP_ROOT   = 5'd5;
    localparam t_op OP_PLAN   = 5'd6;
    localparam t_op OP_COUNT  = 5'd7;
    localparam t_op OP_SCALE  = 5'd8;
    localparam t_op OP_ARCEND = 5'd9;
    localparam t_op OP_START  = 5'd10;
    localparam t_op OP_MULX   = 5'd11;
    localparam t_op OP_DIVX   = 5'd12;
    localparam t_op OP_SAVEX  = 5'd13;
    localparam t_op OP_MULY   = 5'd14;
    localparam t_op OP_DIVY   = 5'd15;
    localparam t_op OP_EMIT   = 5'd16;
    localparam t_op OP_DONE   = 5'd17;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic line_start;
        logic root_busy;
        logic div_busy;
        logic start_needed;
        logic emit_more;
        logic last_emit;
        logic out_free;
    } t_stat;

endpackage

// ===== src/polyline_arc_length_resampler.sv =====
// ----------------------------------------------------------------------------
// polyline_arc_length_resampler
// Resamples a polyline to points spaced one arc length step apart.
//
//   channel  dir  handshake                  payload
//   in       in   i_in_valid / o_in_ready    begin_line, vertex_x, vertex_y
//   out      out  o_out_valid / i_out_ready  arc_mm, sample_x, sample_y,
//                                            last_of_run, truncated
//   cfg      in   i_cfg_valid / o_cfg_ready  step_mm
//
// A line start vertex is taken in the idle state. Other vertices go through the
// squares, the 33-step square root and the 33-step sample count (no count
// divide is started when no sample falls on the segment), then two 33-step
// divides per sample through the one divider.
// Synchronous active-low reset; no clearing pass. The input is taken only
// between vertices; a stalled output beat holds the sequencer at its next
// result.
// ----------------------------------------------------------------------------
module polyline_arc_length_resampler #(
    parameter int COORD_BITS              = 32,
    parameter int MAX_SAMPLES_PER_SEGMENT = 63
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [plr_pkg::STEP_W-1:0]  i_step_mm,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_begin_line,
    input  logic signed [31:0]          i_vertex_x,
    input  logic signed [31:0]          i_vertex_y,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [plr_pkg::ARC_W-1:0]   o_arc_mm,
    output logic signed [31:0]          o_sample_x,
    output logic signed [31:0]          o_sample_y,
    output logic                        o_last_of_run,
    output logic                        o_truncated
);

    plr_pkg::t_cmd  cmd;
    plr_pkg::t_stat stat;

    plr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    plr_dp #(
        .COORD_BITS              (COORD_BITS),
        .MAX_SAMPLES_PER_SEGMENT (MAX_SAMPLES_PER_SEGMENT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_valid   (i_cfg_valid),
        .i_step_mm     (i_step_mm),
        .i_begin_line  (i_begin_line),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_arc_mm      (o_arc_mm),
        .o_sample_x    (o_sample_x),
        .o_sample_y    (o_sample_y),
        .o_last_of_run (o_last_of_run),
        .o_truncated   (o_truncated)
    );

    assign o_cfg_ready = 1'b1;

endmodule

// ===== src/plr_div.sv =====
// ----------------------------------------------------------------------------
// plr_div
// Restoring divider, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor.
// ----------------------------------------------------------------------------
module plr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [plr_pkg::PROD_W-1:0]  i_num,
    input  logic [plr_pkg::LEN_W-1:0]   i_den,
    output logic                        o_busy,
    output logic [plr_pkg::LEN_W-1:0]   o_quo,
    output logic [plr_pkg::LEN_W-1:0]   o_rem
);

    logic [plr_pkg::ITER_W-1:0] r_cnt;
    logic [plr_pkg::LEN_W-1:0]  r_rem;
    logic [plr_pkg::LEN_W-1:0]  r_quo;
    logic [plr_pkg::LEN_W-1:0]  r_den;
    logic [plr_pkg::LEN_W:0]    trial;
    logic [plr_pkg::LEN_W:0]    diff;
    logic                       ge;
    logic [plr_pkg::LEN_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_quo[plr_pkg::LEN_W-1]};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
        n_rem = ge ? diff[plr_pkg::LEN_W-1:0] : trial[plr_pkg::LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= plr_pkg::ITER_W'(plr_pkg::DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[plr_pkg::PROD_W-1:plr_pkg::LEN_W];
            r_quo <= i_num[plr_pkg::LEN_W-1:0];
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[plr_pkg::LEN_W-2:0], ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== src/plr_dp.sv =====
// ----------------------------------------------------------------------------
// plr_dp
// Resampler datapath: line state, shared multiplier, bit-serial square root,
// divider, sample accumulators and the result register.
// ----------------------------------------------------------------------------
module plr_dp #(
    parameter int COORD_BITS              = 32,
    parameter int MAX_SAMPLES_PER_SEGMENT = 63
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  plr_pkg::t_cmd                i_cmd,
    output plr_pkg::t_stat               o_stat,
    input  logic                         i_cfg_valid,
    input  logic [plr_pkg::STEP_W-1:0]   i_step_mm,
    input  logic                         i_begin_line,
    input  logic signed [31:0]           i_vertex_x,
    input  logic signed [31:0]           i_vertex_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [plr_pkg::ARC_W-1:0]    o_arc_mm,
    output logic signed [31:0]           o_sample_x,
    output logic signed [31:0]           o_sample_y,
    output logic                         o_last_of_run,
    output logic                         o_truncated
);

    localparam int SHIFT = plr_pkg::COORD_W - COORD_BITS;
    localparam logic [plr_pkg::CNT_W-1:0] MAX_N = plr_pkg::CNT_W'(MAX_SAMPLES_PER_SEGMENT);

    logic [plr_pkg::STEP_W-1:0]  r_step;
    logic [1:0]                  r_phase;
    logic [31:0]                 r_prev_x, r_prev_y, r_cur_x, r_cur_y;
    logic [plr_pkg::STEP_W-1:0]  r_carry;
    logic [plr_pkg::ARC_W-1:0]   r_arc, r_arc_end;
    logic [31:0]                 r_adx, r_ady;
    logic                        r_negx, r_negy;
    logic [plr_pkg::PROD_W-1:0]  r_prod;
    logic [63:0]                 r_acc;
    logic [plr_pkg::PROD_W-1:0]  r_rad;
    logic [35:0]                 r_sqrem;
    logic [plr_pkg::LEN_W-1:0]   r_root;
    logic [plr_pkg::ITER_W-1:0]  r_rcnt;
    logic [plr_pkg::POS_W-1:0]   r_pos;
    logic [plr_pkg::POS_W-1:0]   r_nfull;
    logic                        r_have;
    logic [plr_pkg::CNT_W-1:0]   r_nemit, r_k;
    logic                        r_trunc;
    logic [31:0]                 r_sx;
    logic                        r_o_valid;
    logic [plr_pkg::ARC_W-1:0]   r_o_arc;
    logic [31:0]                 r_o_x, r_o_y;
    logic                        r_o_last, r_o_trunc;

    logic signed [31:0]          x_sh, y_sh, x_ext, y_ext;
    logic [32:0]                 dxw, dyw, adxw, adyw;
    logic [plr_pkg::POS_W-1:0]   mul_a;
    logic [plr_pkg::MUL_B_W-1:0] mul_b;
    logic [plr_pkg::PROD_W-1:0]  mul_p;
    logic [35:0]                 sq_sh, sq_trial;
    logic                        sq_ge;
    logic [64:0]                 sq_sum;
    logic [plr_pkg::STEP_W-1:0]  pos0;
    logic                        active, fits;
    logic                        div_start, div_busy;
    logic [plr_pkg::PROD_W-1:0]  div_num;
    logic [plr_pkg::LEN_W-1:0]   div_den, div_quo, div_rem;
    logic [31:0]                 q32, sx, sy;
    logic [plr_pkg::ARC_W-1:0]   arc_next;
    logic                        out_free;
    logic                        nfull_over;

    always_comb begin
        x_sh   = i_vertex_x <<< SHIFT;
        y_sh   = i_vertex_y <<< SHIFT;
        x_ext  = x_sh >>> SHIFT;
        y_ext  = y_sh >>> SHIFT;
        dxw    = {x_ext[31], x_ext} - {r_prev_x[31], r_prev_x};
        dyw    = {y_ext[31], y_ext} - {r_prev_y[31], r_prev_y};
        adxw   = dxw[32] ? (33'd0 - dxw) : dxw;
        adyw   = dyw[32] ? (33'd0 - dyw) : dyw;

        case (i_cmd.op)
            plr_pkg::OP_SQX: begin
                mul_a = {2'b00, r_adx};
                mul_b = r_adx;
            end
            plr_pkg::OP_SQY: begin
                mul_a = {2'b00, r_ady};
                mul_b = r_ady;
            end
            plr_pkg::OP_MULX: begin
                mul_a = r_pos;
                mul_b = r_adx;
            end
            plr_pkg::OP_MULY: begin
                mul_a = r_pos;
                mul_b = r_ady;
            end
            plr_pkg::OP_SCALE: begin
                mul_a = r_nfull;
                mul_b = {12'd0, r_step};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;

        sq_sh    = {r_sqrem[33:0], r_rad[plr_pkg::PROD_W-1:plr_pkg::PROD_W-2]};
        sq_trial = {1'b0, r_root, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
        sq_sum   = {1'b0, r_acc} + {1'b0, r_prod[63:0]};

        pos0   = (r_carry < r_step) ? (r_step - r_carry) : '0;
        active = (r_step != '0) && (r_root != '0);
        fits   = {13'd0, pos0} <= r_root;

        case (i_cmd.op)
            plr_pkg::OP_PLAN: begin
                div_num = {33'd0, r_root - {13'd0, pos0}};
                div_den = {13'd0, r_step};
            end
            default: begin
                div_num = r_prod;
                div_den = r_root;
            end
        endcase
        div_start = (i_cmd.op == plr_pkg::OP_PLAN && active && fits) ||
                    i_cmd.op == plr_pkg::OP_DIVX || i_cmd.op == plr_pkg::OP_DIVY;

        q32        = div_quo[31:0];
        sx         = r_negx ? (r_prev_x - q32) : (r_prev_x + q32);
        sy         = r_negy ? (r_prev_y - q32) : (r_prev_y + q32);
        arc_next   = r_arc + {20'd0, r_step};
        out_free   = !r_o_valid || i_out_ready;
        nfull_over = r_nfull > {28'd0, MAX_N};
    end

    plr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= plr_pkg::STEP_RESET;
            r_phase   <= plr_pkg::PH_NONE;
            r_rcnt    <= '0;
            r_o_valid <= 1'b0;
            r_k       <= '0;
            r_nemit   <= '0;
            r_carry   <= '0;
            r_arc     <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_step_mm;
            end
            if (r_rcnt != '0) begin
                r_rcnt <= r_rcnt - 1'b1;
            end
            if (i_cmd.op == plr_pkg::OP_START || i_cmd.op == plr_pkg::OP_EMIT) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            case (i_cmd.op)
                plr_pkg::OP_LINE: begin
                    r_carry  <= '0;
                    r_arc    <= '0;
                    r_prev_x <= x_ext;
                    r_prev_y <= y_ext;
                    r_phase  <= plr_pkg::PH_ONE;
                end
                plr_pkg::OP_ROOT: begin
                    r_rcnt <= plr_pkg::ITER_W'(plr_pkg::ROOT_STEPS);
                end
                plr_pkg::OP_PLAN: begin
                    if (active && !fits) begin
                        r_carry <= r_carry + r_root[plr_pkg::STEP_W-1:0];
                    end
                end
                plr_pkg::OP_COUNT: begin
                    if (r_have) begin
                        r_carry <= div_rem[plr_pkg::STEP_W-1:0];
                    end
                end
                plr_pkg::OP_SCALE: begin
                    r_k     <= '0;
                    r_nemit <= nfull_over ? MAX_N : r_nfull[plr_pkg::CNT_W-1:0];
                end
                plr_pkg::OP_EMIT: begin
                    r_arc     <= arc_next;
                    r_k       <= r_k + 1'b1;
                end
                plr_pkg::OP_DONE: begin
                    r_arc    <= r_arc_end;
                    r_prev_x <= r_cur_x;
                    r_prev_y <= r_cur_y;
                    r_phase  <= plr_pkg::PH_MANY;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rcnt != '0) begin
            r_sqrem <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
            r_root  <= {r_root[plr_pkg::LEN_W-2:0], sq_ge};
            r_rad   <= {r_rad[plr_pkg::PROD_W-3:0], 2'b00};
        end
        case (i_cmd.op)
            plr_pkg::OP_LOAD: begin
                r_cur_x <= x_ext;
                r_cur_y <= y_ext;
                r_adx   <= adxw[31:0];
                r_ady   <= adyw[31:0];
                r_negx  <= dxw[32];
                r_negy  <= dyw[32];
            end
            plr_pkg::OP_SQX, plr_pkg::OP_MULX, plr_pkg::OP_MULY: begin
                r_prod <= mul_p;
            end
            plr_pkg::OP_SQY: begin
                r_acc  <= r_prod[63:0];
                r_prod <= mul_p;
            end
            plr_pkg::OP_ROOT: begin
                r_rad   <= {1'b0, sq_sum};
                r_sqrem <= '0;
                r_root  <= '0;
            end
            plr_pkg::OP_PLAN: begin
                r_pos  <= {14'd0, pos0};
                r_have <= active && fits;
            end
            plr_pkg::OP_COUNT: begin
                r_nfull <= r_have ? ({1'b0, div_quo} + 1'b1) : '0;
            end
            plr_pkg::OP_SCALE: begin
                r_prod  <= mul_p;
                r_trunc <= nfull_over;
            end
            plr_pkg::OP_ARCEND: begin
                r_arc_end <= r_arc + r_prod[plr_pkg::ARC_W-1:0];
            end
            plr_pkg::OP_START: begin
                r_o_arc   <= '0;
                r_o_x     <= r_prev_x;
                r_o_y     <= r_prev_y;
                r_o_last  <= r_nemit == '0;
                r_o_trunc <= r_trunc;
            end
            plr_pkg::OP_SAVEX: begin
                r_sx <= sx;
            end
            plr_pkg::OP_EMIT: begin
                r_o_arc   <= arc_next;
                r_o_x     <= r_sx;
                r_o_y     <= sy;
                r_o_last  <= o_stat.last_emit;
                r_o_trunc <= r_trunc;
                r_pos     <= r_pos + {14'd0, r_step};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.line_start   = i_begin_line || (r_phase == plr_pkg::PH_NONE);
        o_stat.root_busy    = r_rcnt != '0;
        o_stat.div_busy     = div_busy;
        o_stat.start_needed = (r_phase == plr_pkg::PH_ONE) && (r_step != '0);
        o_stat.emit_more    = r_nemit != '0;
        o_stat.last_emit    = (r_k + 1'b1) == r_nemit;
        o_stat.out_free     = out_free;
    end

    assign o_out_valid   = r_o_valid;
    assign o_arc_mm      = r_o_arc;
    assign o_sample_x    = r_o_x;
    assign o_sample_y    = r_o_y;
    assign o_last_of_run = r_o_last;
    assign o_truncated   = r_o_trunc;

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_stat.root_busy && div_busy))
        else $error("root and divider busy together");

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= r_nemit)
        else $error("sample index past emit count");

    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == plr_pkg::OP_START || i_cmd.op == plr_pkg::OP_EMIT) |-> out_free)
        else $error("result written over a waiting beat");

endmodule

// ===== src/plr_ctrl.sv =====
// ----------------------------------------------------------------------------
// plr_ctrl
// Sequencer for one vertex: squares, root, sample count, then one
// multiply and divide per coordinate for each sample.
// ----------------------------------------------------------------------------
module plr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  plr_pkg::t_stat i_stat,
    output plr_pkg::t_cmd  o_cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SQX    = 5'd1;
    localparam logic [4:0] S_SQY    = 5'd2;
    localparam logic [4:0] S_ROOT   = 5'd3;
    localparam logic [4:0] S_RWAIT  = 5'd4;
    localparam logic [4:0] S_PLAN   = 5'd5;
    localparam logic [4:0] S_DWAIT  = 5'd6;
    localparam logic [4:0] S_COUNT  = 5'd7;
    localparam logic [4:0] S_SCALE  = 5'd8;
    localparam logic [4:0] S_ARCEND = 5'd9;
    localparam logic [4:0] S_START  = 5'd10;
    localparam logic [4:0] S_MULX   = 5'd11;
    localparam logic [4:0] S_DIVX   = 5'd12;
    localparam logic [4:0] S_XWAIT  = 5'd13;
    localparam logic [4:0] S_SAVEX  = 5'd14;
    localparam logic [4:0] S_MULY   = 5'd15;
    localparam logic [4:0] S_DIVY   = 5'd16;
    localparam logic [4:0] S_YWAIT  = 5'd17;
    localparam logic [4:0] S_EMIT   = 5'd18;
    localparam logic [4:0] S_DONE   = 5'd19;

    logic [4:0] r_state, n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = plr_pkg::OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.line_start) begin
                        o_cmd.op = plr_pkg::OP_LINE;
                    end else begin
                        o_cmd.op = plr_pkg::OP_LOAD;
                        n_state  = S_SQX;
                    end
                end
            end
            S_SQX: begin
                o_cmd.op = plr_pkg::OP_SQX;
                n_state  = S_SQY;
            end
            S_SQY: begin
                o_cmd.op = plr_pkg::OP_SQY;
                n_state  = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.op = plr_pkg::OP_ROOT;
                n_state  = S_RWAIT;
            end
            S_RWAIT: begin
                if (!i_stat.root_busy) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                o_cmd.op = plr_pkg::OP_PLAN;
                n_state  = S_DWAIT;
            end
            S_DWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                o_cmd.op = plr_pkg::OP_COUNT;
                n_state  = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.op = plr_pkg::OP_SCALE;
                n_state  = S_ARCEND;
            end
            S_ARCEND: begin
                o_cmd.op = plr_pkg::OP_ARCEND;
                n_state  = S_START;
            end
            S_START: begin
                if (!i_stat.start_needed || i_stat.out_free) begin
                    if (i_stat.start_needed) begin
                        o_cmd.op = plr_pkg::OP_START;
                    end
                    n_state = i_stat.emit_more ? S_MULX : S_DONE;
                end
            end
            S_MULX: begin
                o_cmd.op = plr_pkg::OP_MULX;
                n_state  = S_DIVX;
            end
            S_DIVX: begin
                o_cmd.op = plr_pkg::OP_DIVX;
                n_state  = S_XWAIT;
            end
            S_XWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_SAVEX;
                end
            end
            S_SAVEX: begin
                o_cmd.op = plr_pkg::OP_SAVEX;
                n_state  = S_MULY;
            end
            S_MULY: begin
                o_cmd.op = plr_pkg::OP_MULY;
                n_state  = S_DIVY;
            end
            S_DIVY: begin
                o_cmd.op = plr_pkg::OP_DIVY;
                n_state  = S_YWAIT;
            end
            S_YWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = plr_pkg::OP_EMIT;
                    n_state  = i_stat.last_emit ? S_DONE : S_MULX;
                end
            end
            S_DONE: begin
                o_cmd.op = plr_pkg::OP_DONE;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

endmodule

// ===== tb/sv/tb_polyline_arc_length_resampler.sv =====
// ----------------------------------------------------------------------------
// tb_polyline_arc_length_resampler
// Drives polyline vertices through the resampler across several step settings
// and checks every sample beat against an in-bench arc length predictor.
// ----------------------------------------------------------------------------
module tb_polyline_arc_length_resampler;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PER_SEG = 63;
    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE      = 300;

    typedef struct {
        logic              begin_line;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_vertex;

    typedef struct {
        logic [plr_pkg::ARC_W-1:0] arc;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
        logic               trunc;
    } t_sample;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [plr_pkg::STEP_W-1:0] cfg_step = '0;
    logic                in_valid = 1'b0;
    logic                o_in_ready;
    logic                in_begin = 1'b0;
    logic signed [31:0]  in_x = '0;
    logic signed [31:0]  in_y = '0;
    logic                o_out_valid;
    logic                out_ready = 1'b0;
    logic [plr_pkg::ARC_W-1:0] o_arc_mm;
    logic signed [31:0]  o_sample_x;
    logic signed [31:0]  o_sample_y;
    logic                o_last_of_run;
    logic                o_truncated;

    t_vertex vertex_q[$];
    t_sample sample_q[$];
    int      errors = 0;
    int      in_gap = 0;
    int      out_gap = 0;
    int      idle_cycles = 0;
    bit      no_idle = 0;

    // predictor state
    logic [plr_pkg::STEP_W-1:0] step_cur;
    logic signed [31:0] last_x;
    logic signed [31:0] last_y;
    logic [plr_pkg::STEP_W-1:0] carry;
    logic [plr_pkg::ARC_W-1:0]  arc_sum;
    logic [1:0]         phase;

    polyline_arc_length_resampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_step_mm     (cfg_step),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_begin_line  (in_begin),
        .i_vertex_x    (in_x),
        .i_vertex_y    (in_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_arc_mm      (o_arc_mm),
        .o_sample_x    (o_sample_x),
        .o_sample_y    (o_sample_y),
        .o_last_of_run (o_last_of_run),
        .o_truncated   (o_truncated)
    );

    always #5 i_clk = ~i_clk;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    function automatic logic [32:0] floor_root(logic [65:0] v);
        logic [32:0] root;
        logic [32:0] t;
        root = '0;
        for (int b = 32; b >= 0; b--) begin
            t = root | (33'd1 << b);
            if ({33'd0, t} * {33'd0, t} <= v) root = t;
        end
        return root;
    endfunction

    task automatic predict_vertex(logic bl, logic signed [31:0] x, logic signed [31:0] y);
        longint            dx, dy, sx, sy;
        logic [32:0]       adx, ady, len;
        logic [65:0]       sq;
        longint unsigned   stp, pos0, nfull, nemit, pos;
        logic [127:0]      qx, qy;
        t_sample           run[$];
        t_sample           s;
        bit                trunc;
        stp = step_cur;
        nfull = 0;
        trunc = 0;
        if (bl || phase == plr_pkg::PH_NONE) begin
            carry = '0;
            arc_sum = '0;
            last_x = x;
            last_y = y;
            phase = plr_pkg::PH_ONE;
            return;
        end
        if (phase == plr_pkg::PH_ONE && stp != 0) begin
            s = '{arc: '0, x: last_x, y: last_y, last: 1'b0, trunc: 1'b0};
            run = {run, s};
        end
        phase = plr_pkg::PH_MANY;
        dx = longint'(x) - longint'(last_x);
        dy = longint'(y) - longint'(last_y);
        adx = dx < 0 ? 33'(-dx) : 33'(dx);
        ady = dy < 0 ? 33'(-dy) : 33'(dy);
        sq = {33'd0, adx} * {33'd0, adx} + {33'd0, ady} * {33'd0, ady};
        len = floor_root(sq);
        if (stp != 0 && len != 0) begin
            pos0 = carry < stp ? stp - carry : 0;
            if (pos0 <= len) begin
                nfull = (len - pos0) / stp + 1;
                carry = plr_pkg::STEP_W'(len - (pos0 + (nfull - 1) * stp));
            end else begin
                carry = plr_pkg::STEP_W'(carry + len);
            end
            nemit = nfull > MAX_PER_SEG ? MAX_PER_SEG : nfull;
            trunc = nfull > nemit;
            for (longint unsigned k = 0; k < nemit; k++) begin
                pos = pos0 + k * stp;
                qx = (128'(pos) * 128'(adx)) / 128'(len);
                qy = (128'(pos) * 128'(ady)) / 128'(len);
                sx = dx < 0 ? longint'(last_x) - longint'(qx) : longint'(last_x) + longint'(qx);
                sy = dy < 0 ? longint'(last_y) - longint'(qy) : longint'(last_y) + longint'(qy);
                arc_sum = arc_sum + plr_pkg::ARC_W'(stp);
                s = '{arc: arc_sum, x: 32'(sx), y: 32'(sy), last: 1'b0, trunc: 1'b0};
                run = {run, s};
            end
            arc_sum = arc_sum + plr_pkg::ARC_W'((nfull - nemit) * stp);
        end
        last_x = x;
        last_y = y;
        foreach (run[i]) begin
            run[i].trunc = trunc;
            run[i].last  = (i == run.size() - 1);
            sample_q = {sample_q, run[i]};
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_vertex v;
        bit      hold;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            hold = 0;
            if (in_valid) begin
                if (o_in_ready) predict_vertex(in_begin, in_x, in_y);
                else hold = 1;
            end
            if (!hold) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (vertex_q.size() > 0) begin
                    v = vertex_q.pop_front();
                    in_begin <= v.begin_line;
                    in_x     <= v.x;
                    in_y     <= v.y;
                    in_valid <= 1'b1;
                    in_gap   = idle_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_sample e;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                if (sample_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected sample arc %0d x %0d y %0d", $realtime,
                             o_arc_mm, o_sample_x, o_sample_y);
                end else begin
                    e = sample_q.pop_front();
                    if (e.arc !== o_arc_mm || e.x !== o_sample_x || e.y !== o_sample_y ||
                        e.last !== o_last_of_run || e.trunc !== o_truncated) begin
                        errors++;
                        $display("%0t: expected arc %0d x %0d y %0d last %0b trunc %0b",
                                 $realtime, e.arc, e.x, e.y, e.last, e.trunc);
                        $display("%0t: actual   arc %0d x %0d y %0d last %0b trunc %0b",
                                 $realtime, o_arc_mm, o_sample_x, o_sample_y,
                                 o_last_of_run, o_truncated);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                out_gap = idle_gap();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_vertex(logic bl, int x, int y);
        t_vertex v;
        v.begin_line = bl;
        v.x = x;
        v.y = y;
        vertex_q = {vertex_q, v};
    endtask

    task automatic drain();
        while (vertex_q.size() > 0 || in_valid || sample_q.size() > 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_step(logic [plr_pkg::STEP_W-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_step  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        step_cur = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic add_walk(int count, int step);
        longint range;
        longint cx, cy;
        int     r;
        cx = last_x;
        cy = last_y;
        range = step == 0 ? 100 : longint'(step) * 3;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                cx = int'($urandom);
                cy = int'($urandom);
            end else if (r < 11) begin
                // repeat the previous point
            end else begin
                cx = int'(cx + longint'($urandom_range(0, 2 * range)) - range);
                cy = int'(cy + longint'($urandom_range(0, 2 * range)) - range);
            end
            push_vertex($urandom_range(0, 99) < 10, int'(cx), int'(cy));
        end
    endtask

    initial begin
        step_cur = plr_pkg::STEP_RESET;
        last_x = '0;
        last_y = '0;
        carry = '0;
        arc_sum = '0;
        phase = plr_pkg::PH_NONE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_vertex(1'b0, 0, 0);
        push_vertex(1'b0, 3000, 4000);
        push_vertex(1'b0, 3000, 4000);
        push_vertex(1'b0, 3500, 4000);
        push_vertex(1'b1, 32'sh8000_0000, 32'sh8000_0000);
        push_vertex(1'b0, 32'sh7fff_ffff, 32'sh7fff_ffff);
        push_vertex(1'b0, 32'sh7fff_ffff, 32'sh8000_0000);
        push_vertex(1'b1, 10, 10);
        push_vertex(1'b0, 10, 10);
        push_vertex(1'b0, -990, 10);
        push_vertex(1'b0, -990, -2990);
        push_vertex(1'b0, 0, 0);
        drain();

        write_step('0);
        add_walk(20, 0);
        drain();

        write_step(20'd1);
        no_idle = 1;
        add_walk(30, 1);
        drain();
        no_idle = 0;

        write_step(20'd1000000);
        add_walk(30, 1000000);
        drain();

        // lower the step mid-line so the carry exceeds it
        write_step(20'd7);
        add_walk(20, 7);
        drain();

        for (int p = 0; p < 6; p++) begin
            int s;
            s = $urandom_range(0, 3) == 0 ? $urandom_range(1, 1000000)
                                          : $urandom_range(1, 5000);
            write_step(20'(s));
            no_idle = (p == 2);
            add_walk(35, s);
            drain();
        end
        no_idle = 0;

        write_step(plr_pkg::STEP_RESET);
        add_walk(20, 1000);
        drain();

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
